/* rtl/bmhq_pkg.sv */
// ----------------------------------------------------------------------------
// bmhq_pkg: shared types, constants and microprogram of the heap queue
// Holds the fixed field widths, the status codes, the control word layout and
// the read-only microprogram that steps the heap datapath.
// ----------------------------------------------------------------------------
package bmhq_pkg;

    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 8;

    localparam logic [DATA_W-1:0] INT_MAX = 32'h7FFF_FFFF;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    localparam int OP_INSERT = 0;
    localparam int OP_REMOVE = 1;

    localparam int STEP_W = 4;

    // Microprogram steps. The last step falls through to step zero.
    typedef enum logic [STEP_W-1:0] {
        S_IDLE     = 4'd0,
        S_DISP     = 4'd1,
        S_INS0     = 4'd2,
        S_INS1     = 4'd3,
        S_INSL     = 4'd4,
        S_INSC     = 4'd5,
        S_INSW     = 4'd6,
        S_SETFULL  = 4'd7,
        S_RM0      = 4'd8,
        S_RM1      = 4'd9,
        S_RM2      = 4'd10,
        S_RML      = 4'd11,
        S_RMB      = 4'd12,
        S_RMW      = 4'd13,
        S_SETEMPTY = 4'd14,
        S_FIN      = 4'd15
    } t_step;

    // Jump conditions.
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_ACCEPT,
        C_OP_REMOVE,
        C_FULL,
        C_EMPTY,
        C_ROOT,
        C_PARENT_LE,
        C_LEAF,
        C_DESCEND,
        C_OUT_BUSY
    } t_cond;

    // Heap read address selection.
    typedef enum logic [2:0] {
        RD_NONE,
        RD_PARENT,
        RD_ROOT,
        RD_LAST,
        RD_CHILDREN
    } t_rdsel;

    // Heap write data selection; the write always goes to the current slot.
    typedef enum logic [1:0] {
        WR_NONE,
        WR_RDATA,
        WR_VAL,
        WR_CHOSEN
    } t_wrsel;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } t_cntop;

    // Slot index updates; the _J forms take effect only when the jump is taken.
    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_ONE,
        IDX_CNT_INC,
        IDX_PARENT_J,
        IDX_CHILD_J
    } t_idxop;

    typedef enum logic [1:0] {
        TOP_HOLD,
        TOP_ZERO,
        TOP_MAX,
        TOP_RDATA
    } t_topop;

    typedef enum logic [1:0] {
        ST_HOLD,
        ST_OK,
        ST_FULL,
        ST_EMPTY
    } t_stop;

    typedef struct packed {
        t_cond  cond;
        t_step  target;
        t_rdsel rd;
        t_wrsel wr;
        t_cntop cnt;
        t_idxop idx;
        t_topop top;
        logic   val_ld;
        t_stop  st;
        logic   emit;
    } t_uword;

    // Flags from the datapath that the sequencer may test.
    typedef struct packed {
        logic op_remove;
        logic full;
        logic empty;
        logic root;
        logic parent_le;
        logic leaf;
        logic descend;
    } t_dp_flags;

    // Flags from the channel handshakes.
    typedef struct packed {
        logic in_valid;
        logic out_busy;
    } t_hs_flags;

    localparam t_uword UW_NOP = '{
        cond:   C_NEVER,
        target: S_IDLE,
        rd:     RD_NONE,
        wr:     WR_NONE,
        cnt:    CNT_HOLD,
        idx:    IDX_HOLD,
        top:    TOP_HOLD,
        val_ld: 1'b0,
        st:     ST_HOLD,
        emit:   1'b0
    };

    // The microprogram: one control word per step.
    function automatic t_uword bmhq_ucode(input t_step step);
        t_uword w;
        w = UW_NOP;
        unique case (step)
            S_IDLE: begin
                w.cond   = C_NO_ACCEPT;
                w.target = S_IDLE;
            end
            S_DISP: begin
                w.cond   = C_OP_REMOVE;
                w.target = S_RM0;
                w.top    = TOP_ZERO;
                w.st     = ST_OK;
            end
            S_INS0: begin
                w.cond   = C_FULL;
                w.target = S_SETFULL;
            end
            S_INS1: begin
                w.cnt = CNT_INC;
                w.idx = IDX_CNT_INC;
            end
            S_INSL: begin
                w.cond   = C_ROOT;
                w.target = S_INSW;
                w.rd     = RD_PARENT;
            end
            S_INSC: begin
                w.cond   = C_PARENT_LE;
                w.target = S_INSL;
                w.wr     = WR_RDATA;
                w.idx    = IDX_PARENT_J;
            end
            S_INSW: begin
                w.cond   = C_ALWAYS;
                w.target = S_FIN;
                w.wr     = WR_VAL;
            end
            S_SETFULL: begin
                w.cond   = C_ALWAYS;
                w.target = S_FIN;
                w.st     = ST_FULL;
            end
            S_RM0: begin
                w.cond   = C_EMPTY;
                w.target = S_SETEMPTY;
                w.rd     = RD_ROOT;
            end
            S_RM1: begin
                w.top = TOP_RDATA;
                w.rd  = RD_LAST;
                w.cnt = CNT_DEC;
                w.idx = IDX_ONE;
            end
            S_RM2: begin
                w.val_ld = 1'b1;
            end
            S_RML: begin
                w.cond   = C_LEAF;
                w.target = S_RMW;
                w.rd     = RD_CHILDREN;
            end
            S_RMB: begin
                w.cond   = C_DESCEND;
                w.target = S_RML;
                w.wr     = WR_CHOSEN;
                w.idx    = IDX_CHILD_J;
            end
            S_RMW: begin
                w.cond   = C_ALWAYS;
                w.target = S_FIN;
                w.wr     = WR_VAL;
            end
            S_SETEMPTY: begin
                w.cond   = C_ALWAYS;
                w.target = S_FIN;
                w.st     = ST_EMPTY;
                w.top    = TOP_MAX;
            end
            S_FIN: begin
                w.cond   = C_OUT_BUSY;
                w.target = S_FIN;
                w.emit   = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

/* rtl/bmhq_sequencer.sv */
// ----------------------------------------------------------------------------
// bmhq_sequencer: step counter and microprogram lookup
// Fetches the control word of the current step, tests its jump condition and
// selects either the jump target or the following step.
// ----------------------------------------------------------------------------
module bmhq_sequencer
    import bmhq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dp_flags i_dp_flags,
    input  t_hs_flags i_hs_flags,
    output t_uword    o_uword,
    output logic      o_taken,
    output logic      o_idle
);

    t_step  r_pc;
    t_step  n_pc;
    t_uword uw;
    logic   taken;

    // Next step.
    always_comb begin
        uw = bmhq_ucode(r_pc);
        unique case (uw.cond)
            C_NEVER:     taken = 1'b0;
            C_ALWAYS:    taken = 1'b1;
            C_NO_ACCEPT: taken = !i_hs_flags.in_valid;
            C_OP_REMOVE: taken = i_dp_flags.op_remove;
            C_FULL:      taken = i_dp_flags.full;
            C_EMPTY:     taken = i_dp_flags.empty;
            C_ROOT:      taken = i_dp_flags.root;
            C_PARENT_LE: taken = i_dp_flags.parent_le;
            C_LEAF:      taken = i_dp_flags.leaf;
            C_DESCEND:   taken = i_dp_flags.descend;
            C_OUT_BUSY:  taken = i_hs_flags.out_busy;
            default:     taken = 1'b0;
        endcase
        n_pc = taken ? uw.target : t_step'(r_pc + STEP_W'(1));
    end

    // Outputs.
    always_comb begin
        o_uword = uw;
        o_taken = taken;
        o_idle  = (r_pc == S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

/* rtl/bmhq_datapath.sv */
// ----------------------------------------------------------------------------
// bmhq_datapath: heap store and working registers
// A one-write, two-read heap memory with registered read data, the entry
// count, the current slot index, the moving value and the compare logic.
// ----------------------------------------------------------------------------
module bmhq_datapath
    import bmhq_pkg::*;
#(
    parameter int CAPACITY = 128
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic                        i_op,
    input  logic [DATA_W-1:0]           i_value,
    input  t_uword                      i_uword,
    input  logic                        i_taken,
    output t_dp_flags                   o_flags,
    output logic [DATA_W-1:0]           o_top,
    output logic [STATUS_W-1:0]         o_status,
    output logic [$clog2(CAPACITY+1)-1:0] o_count
);

    localparam int SW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);

    logic [DATA_W-1:0]   r_heap [CAPACITY];
    logic [DATA_W-1:0]   r_rd_a;
    logic [DATA_W-1:0]   r_rd_b;
    logic [SW-1:0]       r_cnt;
    logic [SW-1:0]       r_idx;
    logic [DATA_W-1:0]   r_val;
    logic [DATA_W-1:0]   r_top;
    logic [STATUS_W-1:0] r_status;
    logic                r_op;

    logic [SW-1:0]     parent_slot;
    logic [SW:0]       left_slot;
    logic [SW:0]       right_slot;
    logic [SW:0]       slot_a;
    logic [SW:0]       slot_a_m1;
    logic [SW-1:0]     idx_m1;
    logic              re_a;
    logic              re_b;
    logic              we;
    logic [DATA_W-1:0] wdata;
    logic              pick_right;
    logic [DATA_W-1:0] chosen;
    logic [SW:0]       child_slot;

    assign parent_slot = r_idx >> 1;
    assign left_slot   = {r_idx, 1'b0};
    assign right_slot  = {r_idx, 1'b1};
    assign slot_a_m1   = slot_a - (SW + 1)'(1);
    assign idx_m1      = r_idx - SW'(1);

    // The larger child; the right one wins only when it exists and is larger.
    assign pick_right = (left_slot < {1'b0, r_cnt}) && ($signed(r_rd_b) > $signed(r_rd_a));
    assign chosen     = pick_right ? r_rd_b : r_rd_a;
    assign child_slot = pick_right ? right_slot : left_slot;

    always_comb begin
        re_a   = 1'b1;
        re_b   = 1'b0;
        slot_a = left_slot;
        unique case (i_uword.rd)
            RD_PARENT:   slot_a = {1'b0, parent_slot};
            RD_ROOT:     slot_a = (SW + 1)'(1);
            RD_LAST:     slot_a = {1'b0, r_cnt};
            RD_CHILDREN: re_b   = 1'b1;
            default:     re_a   = 1'b0;
        endcase
    end

    always_comb begin
        we    = 1'b1;
        wdata = r_val;
        unique case (i_uword.wr)
            WR_RDATA:  wdata = r_rd_a;
            WR_VAL:    wdata = r_val;
            WR_CHOSEN: wdata = chosen;
            default:   we    = 1'b0;
        endcase
    end

    // Heap memory: slot s lives at entry s - 1. Slot 2i + 1 is entry 2i.
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_heap[idx_m1[AW-1:0]] <= wdata;
        end
        if (re_a) begin
            r_rd_a <= r_heap[slot_a_m1[AW-1:0]];
        end
        if (re_b) begin
            r_rd_b <= r_heap[left_slot[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= SW'(1);
        end else begin
            unique case (i_uword.cnt)
                CNT_INC: r_cnt <= r_cnt + SW'(1);
                CNT_DEC: r_cnt <= r_cnt - SW'(1);
                default: r_cnt <= r_cnt;
            endcase
            unique case (i_uword.idx)
                IDX_ONE:      r_idx <= SW'(1);
                IDX_CNT_INC:  r_idx <= r_cnt + SW'(1);
                IDX_PARENT_J: if (i_taken) r_idx <= parent_slot;
                IDX_CHILD_J:  if (i_taken) r_idx <= child_slot[SW-1:0];
                default:      r_idx <= r_idx;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_op  <= i_op;
            r_val <= i_value;
        end else if (i_uword.val_ld) begin
            r_val <= r_rd_a;
        end
        unique case (i_uword.top)
            TOP_ZERO:  r_top <= '0;
            TOP_MAX:   r_top <= INT_MAX;
            TOP_RDATA: r_top <= r_rd_a;
            default:   r_top <= r_top;
        endcase
        unique case (i_uword.st)
            ST_OK:    r_status <= STATUS_OK;
            ST_FULL:  r_status <= STATUS_FULL;
            ST_EMPTY: r_status <= STATUS_EMPTY;
            default:  r_status <= r_status;
        endcase
    end

    always_comb begin
        o_flags.op_remove = (r_op == 1'(OP_REMOVE));
        o_flags.full      = (r_cnt == SW'(CAPACITY));
        o_flags.empty     = (r_cnt == '0);
        o_flags.root      = (r_idx == SW'(1));
        o_flags.parent_le = ($signed(r_rd_a) <= $signed(r_val));
        o_flags.leaf      = (r_idx > (r_cnt >> 1));
        o_flags.descend   = ($signed(r_val) < $signed(chosen));
    end

    assign o_top    = r_top;
    assign o_status = r_status;
    assign o_count  = r_cnt;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= SW'(CAPACITY))
        else $error("Entry count is above the heap capacity.");

endmodule

/* rtl/binary_max_heap_queue.sv */
// ----------------------------------------------------------------------------
// binary_max_heap_queue: priority queue on a binary max-heap
// Each input transaction inserts a value or removes the maximum; each one
// yields exactly one result transaction with value, status and occupancy.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake                   Payload
//   -------  ---------  --------------------------  ----------------------------
//   in       sink       i_in_valid / o_in_stall     i_op, i_value
//   out      source     o_out_valid / i_out_stall   o_result_value, o_status,
//                                                   o_occupancy
//
// Operation: a microprogram walks the heap one level at a time through a
// single write port and two registered read ports. An insert or a remove
// moves its value by at most log2 of CAPACITY levels; refused inserts and
// removes from an empty heap do not walk the heap.
// Reset: synchronous and active low; it empties the heap. The heap memory is
// not cleared, as only slots that hold entries are ever used.
// Stalls: a new transaction is taken whenever the sequencer is idle, even while
// an earlier result waits in the output register; the sequencer holds its last
// step only when that register is still full and stalled.
//
module binary_max_heap_queue
    import bmhq_pkg::*;
#(
    parameter int CAPACITY = 128
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_op,
    input  logic signed [DATA_W-1:0]   i_value,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [DATA_W-1:0]   o_result_value,
    output logic        [STATUS_W-1:0] o_status,
    output logic        [OCC_W-1:0]    o_occupancy
);

    localparam int SW = $clog2(CAPACITY + 1);

    t_dp_flags           dp_flags;
    t_hs_flags           hs_flags;
    t_uword              uword;
    logic                taken;
    logic                idle;
    logic                in_accept;
    logic                out_load;
    logic [DATA_W-1:0]   dp_top;
    logic [STATUS_W-1:0] dp_status;
    logic [SW-1:0]       dp_count;

    logic                r_out_valid;
    logic [DATA_W-1:0]   r_out_value;
    logic [STATUS_W-1:0] r_out_status;
    logic [OCC_W-1:0]    r_out_occ;

    // A transaction is taken only while the sequencer sits in its idle step.
    assign o_in_stall = !idle;
    assign in_accept  = i_in_valid && idle;

    // The output register is busy when its result has not been taken yet.
    assign hs_flags.in_valid = i_in_valid;
    assign hs_flags.out_busy = r_out_valid && i_out_stall;

    // The final step loads the output register once it is free; while it is
    // busy that step jumps to itself and nothing is loaded.
    assign out_load = uword.emit && !taken;

    bmhq_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_dp_flags (dp_flags),
        .i_hs_flags (hs_flags),
        .o_uword    (uword),
        .o_taken    (taken),
        .o_idle     (idle)
    );

    bmhq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_op     (i_op),
        .i_value  (i_value),
        .i_uword  (uword),
        .i_taken  (taken),
        .o_flags  (dp_flags),
        .o_top    (dp_top),
        .o_status (dp_status),
        .o_count  (dp_count)
    );

    // Output register: it parts the result channel from the sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_value  <= dp_top;
            r_out_status <= dp_status;
            r_out_occ    <= OCC_W'(dp_count);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_status       = r_out_status;
    assign o_occupancy    = r_out_occ;

    // A new result must never overwrite one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> !(r_out_valid && i_out_stall))
        else $error("Result loaded while the previous one was still stalled.");

    // A refused insert can only happen with the heap at capacity.
    a_full_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == STATUS_FULL) |-> (o_occupancy == OCC_W'(CAPACITY)))
        else $error("Full status reported below capacity.");

    // A remove from an empty heap returns INT_MAX and leaves the heap empty.
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == STATUS_EMPTY)
            |-> (o_result_value == INT_MAX && o_occupancy == '0))
        else $error("Empty status reported with a wrong value or occupancy.");

endmodule

/* verif/binary_max_heap_queue_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary_max_heap_queue_tb: self-checking bench for the max-heap priority queue
// Drives insert and remove-max transactions and keeps a behavioural heap of its
// own, which forecasts the result of every accepted transaction. Results are
// compared field by field and in order while both channels idle and stall at
// random, including long output hold-offs that fill the block up.
// ----------------------------------------------------------------------------
module binary_max_heap_queue_tb;
    import bmhq_pkg::*;

    localparam int HEAP_DEPTH = 128;
    localparam int BATCH_ITEMS = 250;
    localparam int BATCH_COUNT = 8;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 40;

    localparam logic OP_INS = 1'(OP_INSERT);
    localparam logic OP_REM = 1'(OP_REMOVE);
    localparam logic signed [DATA_W-1:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VALUE_TOP = 32'sh7FFF_FFFE;

    // One input transaction, as queued for the driver.
    typedef struct {
        logic                     op;
        logic signed [DATA_W-1:0] value;
    } t_heap_request;

    // One forecast result transaction.
    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic [STATUS_W-1:0]      status;
        logic [OCC_W-1:0]         occupancy;
    } t_heap_result;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    logic                       i_op = 1'b0;
    logic signed [DATA_W-1:0]   i_value = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic signed [DATA_W-1:0]   o_result_value;
    logic        [STATUS_W-1:0] o_status;
    logic        [OCC_W-1:0]    o_occupancy;

    binary_max_heap_queue #(
        .CAPACITY(HEAP_DEPTH)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_value        (i_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_result_value (o_result_value),
        .o_status       (o_status),
        .o_occupancy    (o_occupancy)
    );

    // Transactions waiting to be driven, and results forecast but not yet seen.
    t_heap_request pending_requests[$];
    t_heap_result  forecast_results[$];

    // The bench's own copy of the heap, held in slots 1 to HEAP_DEPTH.
    logic signed [DATA_W-1:0] shadow_heap [1:HEAP_DEPTH];
    int unsigned              shadow_count = 0;

    // Idling controls; the stimulus process sets the rates and asks for hold-offs.
    int unsigned send_gap_pct = 0;
    int unsigned out_stall_pct = 0;
    int unsigned long_holds_asked = 0;
    int unsigned long_holds_served = 0;
    int unsigned hold_cycles_left = 0;

    // Share of inserts in each random batch. Batches that fill past capacity are
    // later followed by ones that drain past empty, so both refusal cases recur.
    int unsigned insert_bias [BATCH_COUNT] = '{50, 90, 15, 90, 55, 15, 90, 10};

    int unsigned   error_count = 0;
    logic          in_taken = 1'b0;
    t_heap_request next_request;
    t_heap_result  seen_forecast;
    t_heap_result  new_forecast;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Forecast the result of one transaction and update the shadow heap. An
    // insert sifts the value up past every parent that is less than or equal
    // to it; a remove sifts the last entry down from the root, taking the right
    // child only when it is strictly larger, and stopping as soon as the moved
    // entry is not smaller than the chosen child.
    task automatic heap_apply(input logic op, input logic signed [DATA_W-1:0] value,
                              output t_heap_result result);
        int unsigned              slot;
        int unsigned              child;
        logic signed [DATA_W-1:0] moved;
        logic                     settled;
        result.value  = '0;
        result.status = STATUS_OK;
        if (op == OP_INS) begin
            if (shadow_count >= HEAP_DEPTH) begin
                result.status = STATUS_FULL;
            end else begin
                shadow_count = shadow_count + 1;
                slot = shadow_count;
                while (slot > 1 && shadow_heap[slot / 2] <= value) begin
                    shadow_heap[slot] = shadow_heap[slot / 2];
                    slot = slot / 2;
                end
                shadow_heap[slot] = value;
            end
        end else if (shadow_count == 0) begin
            result.value  = INT_MAX;
            result.status = STATUS_EMPTY;
        end else begin
            result.value = shadow_heap[1];
            moved = shadow_heap[shadow_count];
            shadow_count = shadow_count - 1;
            slot = 1;
            settled = 1'b0;
            while (!settled && slot <= shadow_count / 2) begin
                child = 2 * slot;
                if (child < shadow_count && shadow_heap[child] < shadow_heap[child + 1])
                    child = child + 1;
                if (!(moved < shadow_heap[child])) begin
                    settled = 1'b1;
                end else begin
                    shadow_heap[slot] = shadow_heap[child];
                    slot = child;
                end
            end
            shadow_heap[slot] = moved;
        end
        result.occupancy = shadow_count[OCC_W-1:0];
    endtask

    // Input side: every accepted transaction is forecast at the edge that takes it.
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            heap_apply(i_op, i_value, new_forecast);
            forecast_results.push_back(new_forecast);
        end
    end

    // Driver: a new transaction goes out only once the last one has been taken;
    // while it waits the payload is held. Idle cycles carry random payload.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
                next_request = pending_requests.pop_front();
                i_in_valid <= 1'b1;
                i_op       <= next_request.op;
                i_value    <= next_request.value;
            end else begin
                i_in_valid <= 1'b0;
                i_op       <= 1'($urandom);
                i_value    <= $urandom;
            end
        end
    end

    // Output stall: random back-pressure, or a long hold-off when one is asked
    // for. The hold-off length is counted here, so the sender keeps offering
    // transactions until the block itself stalls its input.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_cycles_left != 0) begin
            i_out_stall      <= 1'b1;
            hold_cycles_left <= hold_cycles_left - 1;
        end else if (long_holds_served != long_holds_asked) begin
            i_out_stall       <= 1'b1;
            long_holds_served <= long_holds_served + 1;
            hold_cycles_left  <= LONG_HOLD_CYCLES;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < out_stall_pct);
        end
    end

    // Monitor: each accepted result is checked against the oldest forecast.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (forecast_results.size() == 0) begin
                $error("result transaction with nothing forecast: value %0d status %0d",
                       o_result_value, o_status);
                error_count++;
            end else begin
                seen_forecast = forecast_results.pop_front();
                if (o_result_value !== seen_forecast.value) begin
                    $error("result_value: expected %0d, got %0d",
                           seen_forecast.value, o_result_value);
                    error_count++;
                end
                if (o_status !== seen_forecast.status) begin
                    $error("status: expected %0d, got %0d", seen_forecast.status, o_status);
                    error_count++;
                end
                if (o_occupancy !== seen_forecast.occupancy) begin
                    $error("occupancy: expected %0d, got %0d",
                           seen_forecast.occupancy, o_occupancy);
                    error_count++;
                end
            end
        end
    end

    task automatic queue_request(input logic op, input logic signed [DATA_W-1:0] value);
        t_heap_request request;
        request.op    = op;
        request.value = value;
        pending_requests.push_back(request);
    endtask

    // Values lean towards the extremes and towards a narrow band, so that ties
    // between parents and children occur often; the rest are uniform.
    function automatic logic signed [DATA_W-1:0] pick_value();
        logic signed [DATA_W-1:0] value;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0: value = VALUE_MIN;
                    1: value = VALUE_TOP;
                    2: value = INT_MAX;
                    3: value = -1;
                    default: value = 0;
                endcase
            end
            1, 2, 3: value = $signed($urandom_range(0, 8)) - 4;
            default: value = $urandom;
        endcase
        return value;
    endfunction

    task automatic queue_batch(input int unsigned count, input int unsigned insert_pct);
        repeat (count) begin
            if ($urandom_range(0, 99) < insert_pct)
                queue_request(OP_INS, pick_value());
            else
                queue_request(OP_REM, $urandom);
        end
    endtask

    // Idling modes: none, sender gaps, receiver stalls, and both together.
    task automatic set_idling(input int unsigned mode);
        case (mode)
            0: begin send_gap_pct = 0;  out_stall_pct = 0;  end
            1: begin send_gap_pct = 54; out_stall_pct = 0;  end
            2: begin send_gap_pct = 0;  out_stall_pct = 54; end
            default: begin send_gap_pct = 23; out_stall_pct = 23; end
        endcase
    endtask

    // The sender pauses here until every forecast result has been seen.
    task automatic wait_until_quiet();
        do
            @(negedge i_clk);
        while (pending_requests.size() != 0 || i_in_valid || forecast_results.size() != 0);
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: removes from an empty heap, the extreme values (INT_MAX and
        // VALUE_MIN twice each), and a full drain ending in one more empty remove.
        set_idling(0);
        queue_request(OP_REM, $urandom);
        queue_request(OP_REM, $urandom);
        queue_request(OP_INS, INT_MAX);
        queue_request(OP_INS, VALUE_MIN);
        queue_request(OP_INS, 0);
        queue_request(OP_INS, -1);
        queue_request(OP_INS, VALUE_TOP);
        queue_request(OP_INS, INT_MAX);
        queue_request(OP_INS, VALUE_MIN);
        queue_request(OP_INS, 5);
        queue_request(OP_INS, 5);
        repeat (10) queue_request(OP_REM, $urandom);
        wait_until_quiet();

        // Random part: batches that fill, drain and mix, rotating the idling
        // modes. Two batches also get a long output hold-off.
        for (int unsigned batch = 0; batch < BATCH_COUNT; batch++) begin
            set_idling(batch % 4);
            queue_batch(BATCH_ITEMS, insert_bias[batch]);
            if (batch == 1 || batch == 5)
                long_holds_asked = long_holds_asked + 1;
            wait_until_quiet();
        end

        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (forecast_results.size() != 0) begin
            $error("%0d forecast results never arrived", forecast_results.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog, set well beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
